/* rtl/gqt_pkg.sv */
// Shared types and constants for the graph query tokenizer.
// Holds token kinds, error codes, lexer modes, the result record and the keyword table.
// Depends on nothing.
`default_nettype none
package gqt_pkg;

  localparam int unsigned MAX_TEXT_BYTES = 1048576;
  localparam int unsigned KEYWORD_CHARS  = 8;
  localparam int unsigned NKEYWORDS      = 34;
  localparam int unsigned POS_W          = 21;

  // Position counters stop at these values on overlong text.
  localparam logic [POS_W-1:0] POS_MAX = POS_W'(MAX_TEXT_BYTES);
  localparam logic [POS_W-1:0] OFF_MAX = POS_W'(MAX_TEXT_BYTES - 1);

  // Token kinds.
  localparam logic [5:0] K_END      = 6'd0;
  localparam logic [5:0] K_IDENT    = 6'd1;
  localparam logic [5:0] K_INT      = 6'd2;
  localparam logic [5:0] K_REAL     = 6'd3;
  localparam logic [5:0] K_STRING   = 6'd4;
  localparam logic [5:0] K_PARAM    = 6'd5;
  localparam logic [5:0] K_KW0      = 6'd6;
  localparam logic [5:0] K_LPAREN   = 6'd40;
  localparam logic [5:0] K_RPAREN   = 6'd41;
  localparam logic [5:0] K_LBRACE   = 6'd42;
  localparam logic [5:0] K_RBRACE   = 6'd43;
  localparam logic [5:0] K_LBRACKET = 6'd44;
  localparam logic [5:0] K_RBRACKET = 6'd45;
  localparam logic [5:0] K_COLON    = 6'd46;
  localparam logic [5:0] K_COMMA    = 6'd47;
  localparam logic [5:0] K_DOT      = 6'd48;
  localparam logic [5:0] K_SEMI     = 6'd49;
  localparam logic [5:0] K_PLUS     = 6'd50;
  localparam logic [5:0] K_PLUSEQ   = 6'd51;
  localparam logic [5:0] K_MINUS    = 6'd52;
  localparam logic [5:0] K_ARROW    = 6'd53;
  localparam logic [5:0] K_STAR     = 6'd54;
  localparam logic [5:0] K_SLASH    = 6'd55;
  localparam logic [5:0] K_EQ       = 6'd56;
  localparam logic [5:0] K_NEQ      = 6'd57;
  localparam logic [5:0] K_LT       = 6'd58;
  localparam logic [5:0] K_LE       = 6'd59;
  localparam logic [5:0] K_GT       = 6'd60;
  localparam logic [5:0] K_GE       = 6'd61;

  // Error codes.
  localparam logic [2:0] E_NONE     = 3'd0;
  localparam logic [2:0] E_REAL     = 3'd1;
  localparam logic [2:0] E_INT      = 3'd2;
  localparam logic [2:0] E_UNTERM   = 3'd3;
  localparam logic [2:0] E_ESCAPE   = 3'd4;
  localparam logic [2:0] E_BANG     = 3'd5;
  localparam logic [2:0] E_PARAM    = 3'd6;
  localparam logic [2:0] E_CHAR     = 3'd7;

  // Lexer modes, one-hot.
  typedef enum logic [14:0] {
    M_IDLE    = 15'h0001,
    M_OP      = 15'h0002,
    M_COMMENT = 15'h0004,
    M_WORD    = 15'h0008,
    M_PARAM0  = 15'h0010,
    M_PARAM   = 15'h0020,
    M_STR     = 15'h0040,
    M_ESC     = 15'h0080,
    M_INT     = 15'h0100,
    M_DOT     = 15'h0200,
    M_FRAC    = 15'h0400,
    M_EXPE    = 15'h0800,
    M_EXPS    = 15'h1000,
    M_EXPD    = 15'h2000,
    M_DROP    = 15'h4000
  } lex_mode_t;

  // One result beat.
  typedef struct packed {
    logic [5:0]       kind;
    logic [2:0]       err;
    logic [POS_W-1:0] line;
    logic [POS_W-1:0] column;
    logic [19:0]      offset;
    logic [POS_W-1:0] length;
    logic [63:0]      value;
    logic             last;
  } res_t;

  typedef logic [7:0] word_buf_t [KEYWORD_CHARS];

  // Keyword text, right-justified, first letter in the highest used byte.
  localparam logic [63:0] KW_TEXT [NKEYWORDS] = '{
    64'("CREATE"), 64'("MATCH"), 64'("WHERE"), 64'("RETURN"), 64'("AND"),
    64'("OR"), 64'("NOT"), 64'("AS"), 64'("TRUE"), 64'("FALSE"), 64'("NULL"),
    64'("SET"), 64'("DELETE"), 64'("DETACH"), 64'("REMOVE"), 64'("DISTINCT"),
    64'("ORDER"), 64'("BY"), 64'("LIMIT"), 64'("SKIP"), 64'("OPTIONAL"),
    64'("WITH"), 64'("UNWIND"), 64'("EXISTS"), 64'("IS"), 64'("IN"),
    64'("STARTS"), 64'("ENDS"), 64'("CONTAINS"), 64'("COUNT"), 64'("SUM"),
    64'("AVG"), 64'("MIN"), 64'("MAX")
  };
  localparam logic [3:0] KW_LEN [NKEYWORDS] = '{
    4'd6, 4'd5, 4'd5, 4'd6, 4'd3, 4'd2, 4'd3, 4'd2, 4'd4, 4'd5, 4'd4,
    4'd3, 4'd6, 4'd6, 4'd6, 4'd8, 4'd5, 4'd2, 4'd5, 4'd4, 4'd8,
    4'd4, 4'd6, 4'd6, 4'd2, 4'd2, 4'd6, 4'd4, 4'd8, 4'd5, 4'd3,
    4'd3, 4'd3, 4'd3
  };

  // Kind of a finished word: a keyword when the buffered letters match one exactly.
  function automatic logic [5:0] word_kind(input word_buf_t buf_in, input logic [3:0] len);
    logic [5:0] k;
    logic       hit;
    k = K_IDENT;
    for (int i = 0; i < NKEYWORDS; i++) begin
      hit = (KW_LEN[i] == len);
      for (int j = 0; j < KEYWORD_CHARS; j++) begin
        if (j < int'(KW_LEN[i]) &&
            buf_in[j] != KW_TEXT[i][(int'(KW_LEN[i]) - 1 - j) * 8 +: 8]) begin
          hit = 1'b0;
        end
      end
      if (hit) k = K_KW0 + 6'(i);
    end
    return k;
  endfunction

endpackage
`default_nettype wire

/* rtl/graph_query_tokenizer_top.sv */
// Streaming tokenizer: one text byte per input beat, up to two token beats out.
// A token enters the result queue at the clock edge that accepts the byte that ends it.
// Throughput: one byte per cycle; the four-entry result queue stalls input only
// while it holds three or more beats. Reset returns the lexer to the idle state
// at line 1, column 1, offset 0 and empties the queue.
// Depends on gqt_pkg.
`default_nettype none
module graph_query_tokenizer_top (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  text_byte,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [5:0]       token_kind,
  output logic [2:0]       error_code,
  output logic [20:0]      start_line,
  output logic [20:0]      start_column,
  output logic [19:0]      span_offset,
  output logic [20:0]      span_length,
  output logic [63:0]      int_value,
  output logic             last_of_run
);

  localparam int W = gqt_pkg::POS_W;

  // Lexer state.
  gqt_pkg::lex_mode_t lex_mode, lex_mode_next;
  logic [7:0]   held_char, held_char_next;
  logic [W-1:0] cur_line, cur_line_next, cur_column, cur_column_next;
  logic [W-1:0] cur_offset, cur_offset_next;
  logic [W-1:0] tok_line, tok_line_next, tok_column, tok_column_next;
  logic [W-1:0] tok_offset, tok_offset_next;
  logic [63:0]  int_accum, int_accum_next;
  logic         int_neg, int_neg_next, int_ovf, int_ovf_next;
  gqt_pkg::word_buf_t word_buffer;
  logic [3:0]   word_length, word_length_next;
  logic         buf_we;
  logic [2:0]   buf_idx;
  logic [7:0]   buf_data;

  // Result queue.
  gqt_pkg::res_t fifo [4];
  logic [1:0] rptr, wptr;
  logic [2:0] count;

  logic accept, pop;
  logic [7:0] c;
  logic first_v, second_v, do_start;
  gqt_pkg::res_t first_r, second_r;
  logic c_digit, c_alpha, c_word, c_blank;
  logic [7:0] c_upper;
  logic [W-1:0] off_plus1, gap_tok, gap_tok1;
  logic [67:0] prod;
  logic [67:0] limit;
  logic [5:0] punct;

  assign accept   = in_valid && !in_stall;
  assign pop      = out_valid && !out_stall;
  assign in_stall = (count > 3'd2);
  assign c        = text_byte;

  // Character classes, punctuation kinds, the integer step and the span arithmetic shared by the mode logic.
  always_comb begin
    c_digit   = (c >= "0") && (c <= "9");
    c_alpha   = ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
    c_word    = c_alpha || c_digit || (c == "_");
    c_blank   = (c == " ") || (c == 8'h09) || (c == 8'h0D) || (c == 8'h0A);
    c_upper   = ((c >= "a") && (c <= "z")) ? c - 8'd32 : c;
    off_plus1 = tok_offset + W'(1);
    gap_tok   = (cur_offset > tok_offset) ? cur_offset - tok_offset : '0;
    gap_tok1  = (cur_offset > off_plus1) ? cur_offset - off_plus1 : '0;
    prod      = {1'b0, int_accum, 3'd0} + {3'd0, int_accum, 1'b0} + 68'(c - "0");
    limit     = int_neg ? 68'h0_8000_0000_0000_0000 : 68'h0_7FFF_FFFF_FFFF_FFFF;
    case (c)
      "(":     punct = gqt_pkg::K_LPAREN;
      ")":     punct = gqt_pkg::K_RPAREN;
      "{":     punct = gqt_pkg::K_LBRACE;
      "}":     punct = gqt_pkg::K_RBRACE;
      "[":     punct = gqt_pkg::K_LBRACKET;
      "]":     punct = gqt_pkg::K_RBRACKET;
      ":":     punct = gqt_pkg::K_COLON;
      ",":     punct = gqt_pkg::K_COMMA;
      ".":     punct = gqt_pkg::K_DOT;
      ";":     punct = gqt_pkg::K_SEMI;
      "*":     punct = gqt_pkg::K_STAR;
      "/":     punct = gqt_pkg::K_SLASH;
      "=":     punct = gqt_pkg::K_EQ;
      default: punct = gqt_pkg::K_END;
    endcase
  end

  // One lexer step: the mode logic may finish a token, then the byte may start a new one.
  always_comb begin
    lex_mode_next    = lex_mode;
    held_char_next   = held_char;
    tok_line_next    = tok_line;
    tok_column_next  = tok_column;
    tok_offset_next  = tok_offset;
    int_accum_next   = int_accum;
    int_neg_next     = int_neg;
    int_ovf_next     = int_ovf;
    word_length_next = word_length;
    buf_we   = 1'b0;
    buf_idx  = word_length[2:0];
    buf_data = c_upper;
    first_v  = 1'b0;
    second_v = 1'b0;
    first_r  = '0;
    second_r = '0;
    do_start = 1'b0;
    first_r.line   = tok_line;
    first_r.column = tok_column;
    first_r.offset = tok_offset[19:0];

    case (lex_mode)
      gqt_pkg::M_IDLE: do_start = 1'b1;
      gqt_pkg::M_OP: begin
        if (held_char == "-") begin
          if (c == "-") begin
            lex_mode_next = gqt_pkg::M_COMMENT;
          end else if (c_digit) begin
            lex_mode_next  = gqt_pkg::M_INT;
            int_neg_next   = 1'b1;
            int_ovf_next   = 1'b0;
            int_accum_next = 64'(c - "0");
          end else if (c == ">") begin
            first_v = 1'b1; first_r.kind = gqt_pkg::K_ARROW; first_r.length = W'(2);
            lex_mode_next = gqt_pkg::M_IDLE;
          end else begin
            first_v = 1'b1; first_r.kind = gqt_pkg::K_MINUS; first_r.length = W'(1);
            do_start = 1'b1;
          end
        end else if (held_char == "!") begin
          first_v = 1'b1;
          if (c == "=") begin
            first_r.kind = gqt_pkg::K_NEQ; first_r.length = W'(2);
            lex_mode_next = gqt_pkg::M_IDLE;
          end else begin
            first_r = '0; first_r.err = gqt_pkg::E_BANG;
            first_r.line = cur_line; first_r.column = cur_column;
            lex_mode_next = gqt_pkg::M_DROP;
          end
        end else if (c == "=") begin
          first_v = 1'b1; first_r.length = W'(2);
          first_r.kind = (held_char == "+") ? gqt_pkg::K_PLUSEQ :
                         (held_char == "<") ? gqt_pkg::K_LE : gqt_pkg::K_GE;
          lex_mode_next = gqt_pkg::M_IDLE;
        end else begin
          first_v = 1'b1; first_r.length = W'(1);
          first_r.kind = (held_char == "+") ? gqt_pkg::K_PLUS :
                         (held_char == "<") ? gqt_pkg::K_LT : gqt_pkg::K_GT;
          do_start = 1'b1;
        end
      end
      gqt_pkg::M_COMMENT: begin
        if (c == 8'h0A || c == 8'h00) do_start = 1'b1;
      end
      gqt_pkg::M_WORD: begin
        if (c_word) begin
          if (word_length < 4'(gqt_pkg::KEYWORD_CHARS)) begin
            buf_we = 1'b1;
            word_length_next = word_length + 4'd1;
          end else begin
            word_length_next = 4'(gqt_pkg::KEYWORD_CHARS + 1);
          end
        end else begin
          first_v = 1'b1;
          first_r.kind = (word_length == 4'd0) ? gqt_pkg::K_IDENT :
                         gqt_pkg::word_kind(word_buffer, word_length);
          first_r.length = gap_tok;
          do_start = 1'b1;
        end
      end
      gqt_pkg::M_PARAM0: begin
        if (c_alpha || c == "_") begin
          lex_mode_next = gqt_pkg::M_PARAM;
        end else begin
          first_v = 1'b1; first_r = '0; first_r.err = gqt_pkg::E_PARAM;
          first_r.line = cur_line; first_r.column = cur_column;
          lex_mode_next = gqt_pkg::M_DROP;
        end
      end
      gqt_pkg::M_PARAM: begin
        if (!c_word) begin
          first_v = 1'b1; first_r.kind = gqt_pkg::K_PARAM;
          first_r.offset = off_plus1[19:0]; first_r.length = gap_tok1;
          do_start = 1'b1;
        end
      end
      gqt_pkg::M_STR: begin
        if (c == 8'h00 || c == 8'h0A) begin
          first_v = 1'b1; first_r = '0; first_r.err = gqt_pkg::E_UNTERM;
          first_r.line = cur_line; first_r.column = cur_column;
          lex_mode_next = gqt_pkg::M_DROP;
        end else if (c == 8'h22) begin
          first_v = 1'b1; first_r.kind = gqt_pkg::K_STRING;
          first_r.offset = off_plus1[19:0]; first_r.length = gap_tok1;
          lex_mode_next = gqt_pkg::M_IDLE;
        end else if (c == 8'h5C) begin
          lex_mode_next = gqt_pkg::M_ESC;
        end
      end
      gqt_pkg::M_ESC: begin
        if (c == 8'h22 || c == 8'h5C) begin
          lex_mode_next = gqt_pkg::M_STR;
        end else begin
          first_v = 1'b1; first_r = '0; first_r.err = gqt_pkg::E_ESCAPE;
          first_r.line = cur_line; first_r.column = cur_column;
          lex_mode_next = gqt_pkg::M_DROP;
        end
      end
      gqt_pkg::M_INT: begin
        if (c_digit) begin
          if (!int_ovf) begin
            if (prod > limit) int_ovf_next = 1'b1;
            else int_accum_next = prod[63:0];
          end
        end else if (c == ".") begin
          lex_mode_next = gqt_pkg::M_DOT;
        end else if (int_ovf) begin
          first_v = 1'b1; first_r = '0; first_r.err = gqt_pkg::E_INT;
          first_r.line = cur_line; first_r.column = cur_column;
          lex_mode_next = gqt_pkg::M_DROP;
        end else begin
          first_v = 1'b1; first_r.kind = gqt_pkg::K_INT; first_r.length = gap_tok;
          first_r.value = int_neg ? 64'd0 - int_accum : int_accum;
          do_start = 1'b1;
        end
      end
      gqt_pkg::M_DOT, gqt_pkg::M_EXPS: begin
        if (c_digit) begin
          lex_mode_next = (lex_mode == gqt_pkg::M_DOT) ? gqt_pkg::M_FRAC : gqt_pkg::M_EXPD;
        end else begin
          first_v = 1'b1; first_r = '0; first_r.err = gqt_pkg::E_REAL;
          first_r.line = cur_line; first_r.column = cur_column;
          lex_mode_next = gqt_pkg::M_DROP;
        end
      end
      gqt_pkg::M_FRAC, gqt_pkg::M_EXPD: begin
        if (c_digit) begin
          lex_mode_next = lex_mode;
        end else if (lex_mode == gqt_pkg::M_FRAC && (c == "e" || c == "E")) begin
          lex_mode_next = gqt_pkg::M_EXPE;
        end else begin
          first_v = 1'b1; first_r.kind = gqt_pkg::K_REAL; first_r.length = gap_tok;
          do_start = 1'b1;
        end
      end
      gqt_pkg::M_EXPE: begin
        if (c == "+" || c == "-") begin
          lex_mode_next = gqt_pkg::M_EXPS;
        end else if (c_digit) begin
          lex_mode_next = gqt_pkg::M_EXPD;
        end else begin
          first_v = 1'b1; first_r = '0; first_r.err = gqt_pkg::E_REAL;
          first_r.line = cur_line; first_r.column = cur_column;
          lex_mode_next = gqt_pkg::M_DROP;
        end
      end
      default: lex_mode_next = gqt_pkg::M_DROP;
    endcase

    // The byte lexed with no token in progress.
    if (do_start) begin
      lex_mode_next   = gqt_pkg::M_IDLE;
      tok_line_next   = cur_line;
      tok_column_next = cur_column;
      tok_offset_next = cur_offset;
      second_r.line   = cur_line;
      second_r.column = cur_column;
      second_r.offset = cur_offset[19:0];
      if (c == 8'h00) begin
        second_v = 1'b1; second_r.kind = gqt_pkg::K_END;
      end else if (c_blank) begin
        second_v = 1'b0;
      end else if (c_alpha || c == "_") begin
        lex_mode_next = gqt_pkg::M_WORD;
        buf_we = 1'b1; buf_idx = 3'd0;
        word_length_next = 4'd1;
      end else if (c_digit) begin
        lex_mode_next  = gqt_pkg::M_INT;
        int_neg_next   = 1'b0;
        int_ovf_next   = 1'b0;
        int_accum_next = 64'(c - "0");
      end else if (c == "+" || c == "-" || c == "<" || c == ">" || c == "!") begin
        lex_mode_next  = gqt_pkg::M_OP;
        held_char_next = c;
      end else if (c == 8'h22) begin
        lex_mode_next = gqt_pkg::M_STR;
      end else if (c == "$") begin
        lex_mode_next = gqt_pkg::M_PARAM0;
      end else if (punct != gqt_pkg::K_END) begin
        second_v = 1'b1; second_r.kind = punct; second_r.length = W'(1);
      end else begin
        second_v = 1'b1; second_r.err = gqt_pkg::E_CHAR; second_r.offset = '0;
        lex_mode_next = gqt_pkg::M_DROP;
      end
    end

    first_r.last  = !second_v;
    second_r.last = 1'b1;

    // Position tracking; the end byte starts a new text.
    if (c == 8'h00) begin
      lex_mode_next   = gqt_pkg::M_IDLE;
      cur_line_next   = W'(1);
      cur_column_next = W'(1);
      cur_offset_next = '0;
    end else begin
      cur_line_next   = cur_line;
      cur_column_next = cur_column;
      if (c == 8'h0A) begin
        if (cur_line < gqt_pkg::POS_MAX) cur_line_next = cur_line + W'(1);
        cur_column_next = W'(1);
      end else if (cur_column < gqt_pkg::POS_MAX) begin
        cur_column_next = cur_column + W'(1);
      end
      cur_offset_next = (cur_offset < gqt_pkg::OFF_MAX) ? cur_offset + W'(1) : cur_offset;
    end
  end

  // State registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      lex_mode    <= gqt_pkg::M_IDLE;
      held_char   <= '0;
      cur_line    <= W'(1);
      cur_column  <= W'(1);
      cur_offset  <= '0;
      tok_line    <= W'(1);
      tok_column  <= W'(1);
      tok_offset  <= '0;
      int_accum   <= '0;
      int_neg     <= 1'b0;
      int_ovf     <= 1'b0;
      word_length <= '0;
    end else if (accept) begin
      lex_mode    <= lex_mode_next;
      held_char   <= held_char_next;
      cur_line    <= cur_line_next;
      cur_column  <= cur_column_next;
      cur_offset  <= cur_offset_next;
      tok_line    <= tok_line_next;
      tok_column  <= tok_column_next;
      tok_offset  <= tok_offset_next;
      int_accum   <= int_accum_next;
      int_neg     <= int_neg_next;
      int_ovf     <= int_ovf_next;
      word_length <= word_length_next;
    end
  end

  // Letter buffer for keyword matching.
  always_ff @(posedge clk) begin
    if (accept && buf_we) begin
      word_buffer[buf_idx] <= buf_data;
    end
  end

  // Result queue: up to two beats written per accepted byte, one read per beat out.
  always_ff @(posedge clk) begin
    if (accept && (first_v || second_v)) begin
      fifo[wptr] <= first_v ? first_r : second_r;
    end
    if (accept && first_v && second_v) begin
      fifo[wptr + 2'd1] <= second_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rptr  <= '0;
      wptr  <= '0;
      count <= '0;
    end else begin
      if (accept) wptr <= wptr + 2'({1'b0, first_v} + {1'b0, second_v});
      if (pop) rptr <= rptr + 2'd1;
      count <= count + (accept ? 3'({2'b0, first_v} + {2'b0, second_v}) : 3'd0)
               - {2'b0, pop};
    end
  end

  assign out_valid    = (count != 3'd0);
  assign token_kind   = fifo[rptr].kind;
  assign error_code   = fifo[rptr].err;
  assign start_line   = fifo[rptr].line;
  assign start_column = fifo[rptr].column;
  assign span_offset  = fifo[rptr].offset;
  assign span_length  = fifo[rptr].length;
  assign int_value    = fifo[rptr].value;
  assign last_of_run  = fifo[rptr].last;

endmodule
`default_nettype wire
